/* hdl/mexp_pkg.sv */
`timescale 1ns / 1ps
package mexp_pkg;
   localparam int FIELD_W = 64;
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 72;

   typedef struct packed {
      logic load;
      logic reduce_start;
      logic mul_start;
      logic mul_sel_acc;
      logic shift_exp;
   } cmd_type;

   typedef struct packed {
      logic zero_mod;
      logic exp_bit;
      logic busy;
   } stat_type;
endpackage

/* hdl/mexp_datapath.sv */
`timescale 1ns / 1ps
module mexp_datapath #(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WIDTH-1:0]      base_in,
   input  logic [WIDTH-1:0]      exp_in,
   input  logic [WIDTH-1:0]      mod_in,
   input  mexp_pkg::cmd_type     cmd,
   output mexp_pkg::stat_type    stat,
   output logic [WIDTH-1:0]      result
);
   import mexp_pkg::*;
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] n_ff, sq_ff, acc_ff, exp_ff, x_ff, y_ff, p_ff;
   logic [WIDTH-1:0] n_in, sq_in, acc_in, exp_in_r, x_in, y_in, p_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, dst_acc_ff, dst_acc_in;
   logic [WIDTH:0] dbl, sum, dbl_r, sum_r;
   logic [WIDTH-1:0] step;

   // one shift-add step: p = 2p (+y) mod n; reduction of a uses y=1 and bits of a
   always_comb begin
      dbl = {p_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, n_ff}) ? dbl - {1'b0, n_ff} : dbl;
      sum = dbl_r + (x_ff[WIDTH-1] ? {1'b0, y_ff} : '0);
      sum_r = (sum >= {1'b0, n_ff}) ? sum - {1'b0, n_ff} : sum;
      step = sum_r[WIDTH-1:0];
   end

   always_comb begin
      n_in = n_ff; sq_in = sq_ff; acc_in = acc_ff; exp_in_r = exp_ff;
      x_in = x_ff; y_in = y_ff; p_in = p_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; dst_acc_in = dst_acc_ff;
      if (cmd.load) begin
         n_in = mod_in;
         exp_in_r = exp_in;
         sq_in = base_in;
         acc_in = (mod_in == WIDTH'(1)) ? '0 : WIDTH'(1);
      end
      if (cmd.shift_exp) exp_in_r = exp_ff >> 1;
      if (cmd.reduce_start) begin
         // a mod n = a*1 mod n via shift-add with y=1; a is held in sq
         x_in = sq_ff; y_in = WIDTH'(1); p_in = '0;
         cnt_in = CW'(WIDTH); busy_in = 1'b1; dst_acc_in = 1'b0;
      end else if (cmd.mul_start) begin
         x_in = cmd.mul_sel_acc ? acc_ff : sq_ff; y_in = sq_ff; p_in = '0;
         cnt_in = CW'(WIDTH); busy_in = 1'b1;
         dst_acc_in = cmd.mul_sel_acc;
      end else if (busy_ff) begin
         p_in = step;
         x_in = x_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            if (dst_acc_ff) acc_in = step;
            else sq_in = step;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; sq_ff <= sq_in; acc_ff <= acc_in; exp_ff <= exp_in_r;
      x_ff <= x_in; y_ff <= y_in; p_ff <= p_in; cnt_ff <= cnt_in;
      dst_acc_ff <= dst_acc_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign stat = '{zero_mod: (n_ff == '0), exp_bit: exp_ff[0], busy: busy_ff};
   assign result = acc_ff;
endmodule

/* hdl/mexp_control.sv */
`timescale 1ns / 1ps
module mexp_control #(
   parameter int WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_free,
   input  mexp_pkg::stat_type stat,
   output mexp_pkg::cmd_type  cmd,
   output logic               idle,
   output logic               done
);
   import mexp_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_BIT = 3'd3,
                          S_MUL = 3'd4, S_SQ = 3'd5, S_WAIT = 3'd6, S_DONE = 3'd7;
   localparam int CW = $clog2(WIDTH + 1);

   logic [2:0] state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] bit_ff, bit_in;

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; bit_in = bit_ff;
      cmd = '0; done = 1'b0;
      idle = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: if (req_fire) begin cmd.load = 1'b1; state_in = S_CHECK; end
         S_CHECK: begin
            if (stat.zero_mod) state_in = S_DONE;
            else begin
               cmd.reduce_start = 1'b1; ret_in = S_BIT; state_in = S_WAIT;
               bit_in = CW'(WIDTH);
            end
         end
         S_BIT: begin
            if (bit_ff == '0) state_in = S_DONE;
            else if (stat.exp_bit) state_in = S_MUL;
            else state_in = S_SQ;
         end
         S_MUL: begin
            cmd.mul_start = 1'b1; cmd.mul_sel_acc = 1'b1;
            ret_in = S_SQ; state_in = S_WAIT;
         end
         S_SQ: begin
            cmd.mul_start = 1'b1; cmd.shift_exp = 1'b1;
            bit_in = bit_ff - CW'(1);
            ret_in = S_BIT; state_in = S_WAIT;
         end
         S_WAIT: if (!stat.busy) state_in = ret_ff;
         S_DONE: if (rsp_free) begin done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in; bit_ff <= bit_in;
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

/* hdl/modular_exponentiation.sv */
`timescale 1ns / 1ps
// Modular exponentiation, right-to-left square-and-multiply.
// Input channel req_: one transaction carries base, exponent, modulus.
// Output channel rsp_: one transaction per input with power_residue and
// zero_modulus_error. Only the low WIDTH bits of each operand are used.
// Every modular product runs through one shared shift-add reducer; the base is
// first reduced that way. A zero modulus skips the reducer. One item is in
// work at a time; the next is taken once the result moves into the output
// register.
// Reset (synchronous, active high) empties the output register and returns
// the controller to idle. When the receiver stalls the result holds in the
// output register; a finished item waits for the register to empty before
// it is posted, and no new item is accepted until then.
module modular_exponentiation #(
   parameter int WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mexp_pkg::REQ_DATA_W-1:0]     req_tdata,  // base, exponent, modulus
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mexp_pkg::RSP_DATA_W-1:0]     rsp_tdata   // power_residue, zero_modulus_error, pad
);
   import mexp_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic idle, done, req_fire, rsp_free;
   logic [WIDTH-1:0] result;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = idle;
   assign req_fire = req_tvalid & idle;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   mexp_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock, .reset,
      .base_in(req_tdata[WIDTH-1:0]),
      .exp_in(req_tdata[FIELD_W +: WIDTH]),
      .mod_in(req_tdata[2*FIELD_W +: WIDTH]),
      .cmd, .stat, .result
   );

   mexp_control #(.WIDTH(WIDTH)) u_ctl (
      .clock, .reset, .req_fire, .rsp_free, .stat, .cmd, .idle, .done
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff & !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         if (stat.zero_mod) rsp_data_in[FIELD_W] = 1'b1;
         else rsp_data_in[WIDTH-1:0] = result;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule
